// ----- rtl/core/bpc_pkg.sv -----
package bpc_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_TRIP  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_PRE  = 2'd1,
    PHASE_WAIT = 2'd2,
    PHASE_RUN  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_CHARGE    = 3'd1,
    CAUSE_DISCHARGE = 3'd2,
    CAUSE_CELL_OVER = 3'd3,
    CAUSE_CELL_UNDR = 3'd4,
    CAUSE_ESTOP     = 3'd5
  } cause_t;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_LIM    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISCHARGE_LIM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_OVER     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_UNDER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRECHARGE_MS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_MS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS       = 3'd6;

  localparam logic [15:0] RST_CHARGE_LIM    = 16'hFFEC;  // -20
  localparam logic [15:0] RST_DISCHARGE_LIM = 16'd100;
  localparam logic [15:0] RST_CELL_OVER     = 16'd4;
  localparam logic [15:0] RST_CELL_UNDER    = 16'd2;
  localparam logic [15:0] RST_PRECHARGE_MS  = 16'd3000;
  localparam logic [15:0] RST_BLINK_MS      = 16'd500;
  localparam logic [15:0] RST_HOLD_MS       = 16'd1000;

  localparam logic [10:0] ID_BATT_CURRENT = 11'h6B0;
  localparam logic [10:0] ID_CELL_VOLTAGE = 11'h6B2;

  // contactor bit positions
  localparam logic [2:0] CON_PRE = 3'b001;
  localparam logic [2:0] CON_POS = 3'b010;
  localparam logic [2:0] CON_NEG = 3'b100;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 16;

  typedef struct packed {
    logic signed [15:0] charge_lim;
    logic signed [15:0] discharge_lim;
    logic [15:0]        cell_over;
    logic [15:0]        cell_under;
    logic [15:0]        precharge_ms;
    logic [15:0]        blink_ms;
    logic [15:0]        hold_ms;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic        estop_level;
    logic [10:0] frame_id;
    logic [63:0] frame_data;
  } item_t;

  typedef struct packed {
    cause_t     fault_cause;
    phase_t     phase;
    logic       fault_active;
    logic       fault_lamp;
    logic       negative_closed;
    logic       positive_closed;
    logic       precharge_closed;
  } result_t;

  function automatic logic [15:0] inc_sat(input logic [15:0] v);
    inc_sat = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

// ----- rtl/core/battery_protection_controller.sv -----
// Battery protection controller.
// Input stream (s_axis_*): one beat per event. tuser carries the event kind
// (tick, CAN frame, e-stop trip edge); tdata carries the e-stop level, the
// CAN identifier and the 8-byte payload. Every beat yields exactly one
// result beat on m_axis_*: contactor drives, lamp, fault flag, phase and
// latched fault cause, as they stand after that event.
// Config port (cfg_*): index selects one of seven 16-bit limit/timer
// registers; always ready. Write only while no beat is in flight.
// Pipeline: a beat accepted on s_axis is registered in the input register, then
// evaluated against the state; the updated state/result registers show on m_axis.
// Throughput: one beat per cycle while m_axis is not stalled, set by the single evaluate-and-update
// stage between the input register and the state/result registers.
// Stall: while m_axis_tready is low the result holds; one further beat can
// wait in the input register, after which s_axis_tready drops.
// Reset (rst, synchronous): all contactors open, phase idle, no fault,
// timers cleared, limits back to their defaults, both stages empty.
module battery_protection_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [0] estop_level, [11:1] frame_id, [75:12] frame_data, [79:76] zero
  input  logic [bpc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] precharge_closed, [1] positive_closed, [2] negative_closed,
  // [3] fault_lamp, [4] fault_active, [6:5] phase, [9:7] fault_cause, [15:10] zero
  output logic [bpc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                      cfg_data
);

  logic              in_valid;
  bpc_pkg::item_t    in_item;
  logic              step;
  bpc_pkg::cfg_t     cfg;
  bpc_pkg::result_t  res;

  assign step          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.kind        <= bpc_pkg::kind_t'(s_axis_tuser);
      in_item.estop_level <= s_axis_tdata[0];
      in_item.frame_id    <= s_axis_tdata[11:1];
      in_item.frame_data  <= s_axis_tdata[75:12];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  bpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bpc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  assign m_axis_tdata = {6'd0, res};

endmodule

// ----- rtl/core/bpc_cfg_regs.sv -----
module bpc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [15:0]                    wr_data,
  output bpc_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.charge_lim    <= bpc_pkg::RST_CHARGE_LIM;
      cfg.discharge_lim <= bpc_pkg::RST_DISCHARGE_LIM;
      cfg.cell_over     <= bpc_pkg::RST_CELL_OVER;
      cfg.cell_under    <= bpc_pkg::RST_CELL_UNDER;
      cfg.precharge_ms  <= bpc_pkg::RST_PRECHARGE_MS;
      cfg.blink_ms      <= bpc_pkg::RST_BLINK_MS;
      cfg.hold_ms       <= bpc_pkg::RST_HOLD_MS;
    end else if (wr_en) begin
      case (wr_index)
        bpc_pkg::REG_CHARGE_LIM:    cfg.charge_lim    <= wr_data;
        bpc_pkg::REG_DISCHARGE_LIM: cfg.discharge_lim <= wr_data;
        bpc_pkg::REG_CELL_OVER:     cfg.cell_over     <= wr_data;
        bpc_pkg::REG_CELL_UNDER:    cfg.cell_under    <= wr_data;
        bpc_pkg::REG_PRECHARGE_MS:  cfg.precharge_ms  <= wr_data;
        bpc_pkg::REG_BLINK_MS:      cfg.blink_ms      <= wr_data;
        bpc_pkg::REG_HOLD_MS:       cfg.hold_ms       <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/bpc_core.sv -----
module bpc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  bpc_pkg::item_t   item,
  input  bpc_pkg::cfg_t    cfg,
  output bpc_pkg::result_t res
);

  logic             fault_flag, fault_flag_next;
  bpc_pkg::cause_t  cause_reg, cause_reg_next;
  bpc_pkg::phase_t  phase_reg, phase_reg_next;
  logic [2:0]       contactor_bits, contactor_bits_next;
  logic             lamp_reg, lamp_reg_next;
  logic [15:0]      wait_timer, wait_timer_next;
  logic [15:0]      blink_timer, blink_timer_next;
  logic [15:0]      hold_timer, hold_timer_next;
  logic             holding_flag, holding_flag_next;

  logic [15:0]        blink_inc;
  logic [15:0]        hold_inc;
  logic [15:0]        wait_inc;
  logic signed [15:0] batt_current;
  logic [15:0]        cell_high;
  logic [15:0]        cell_low;
  logic               frame_fault;
  bpc_pkg::cause_t    frame_cause;

  assign blink_inc    = bpc_pkg::inc_sat(blink_timer);
  assign hold_inc     = bpc_pkg::inc_sat(hold_timer);
  assign wait_inc     = bpc_pkg::inc_sat(wait_timer);
  assign batt_current = item.frame_data[63:48];
  assign cell_high    = item.frame_data[63:48];
  assign cell_low     = item.frame_data[39:24];

  // frame decode: current checked charge first, cells checked high first
  always_comb begin
    frame_fault = 1'b0;
    frame_cause = bpc_pkg::CAUSE_NONE;
    if (item.frame_id == bpc_pkg::ID_BATT_CURRENT) begin
      if (batt_current < cfg.charge_lim) begin
        frame_fault = 1'b1;
        frame_cause = bpc_pkg::CAUSE_CHARGE;
      end else if (batt_current > cfg.discharge_lim) begin
        frame_fault = 1'b1;
        frame_cause = bpc_pkg::CAUSE_DISCHARGE;
      end
    end else if (item.frame_id == bpc_pkg::ID_CELL_VOLTAGE) begin
      if (cell_high > cfg.cell_over) begin
        frame_fault = 1'b1;
        frame_cause = bpc_pkg::CAUSE_CELL_OVER;
      end else if (cell_low <= cfg.cell_under) begin
        frame_fault = 1'b1;
        frame_cause = bpc_pkg::CAUSE_CELL_UNDR;
      end
    end
  end

  always_comb begin
    fault_flag_next     = fault_flag;
    cause_reg_next      = cause_reg;
    phase_reg_next      = phase_reg;
    contactor_bits_next = contactor_bits;
    lamp_reg_next       = lamp_reg;
    wait_timer_next     = wait_timer;
    blink_timer_next    = blink_timer;
    hold_timer_next     = hold_timer;
    holding_flag_next   = holding_flag;
    case (item.kind)
      bpc_pkg::KIND_TICK: begin
        blink_timer_next = blink_inc;
        if (fault_flag) begin
          if (blink_inc >= cfg.blink_ms) begin
            lamp_reg_next    = ~lamp_reg;
            blink_timer_next = 16'd0;
          end
          if (!item.estop_level) begin
            if (!holding_flag) begin
              holding_flag_next = 1'b1;
              hold_timer_next   = 16'd0;
            end else begin
              hold_timer_next = hold_inc;
              if (hold_inc > cfg.hold_ms) begin
                fault_flag_next     = 1'b0;
                cause_reg_next      = bpc_pkg::CAUSE_NONE;
                holding_flag_next   = 1'b0;
                hold_timer_next     = 16'd0;
                lamp_reg_next       = 1'b0;
                contactor_bits_next = 3'b000;
                phase_reg_next      = bpc_pkg::PHASE_IDLE;
              end
            end
          end else begin
            holding_flag_next = 1'b0;
          end
        end else begin
          lamp_reg_next = 1'b0;
          case (phase_reg)
            bpc_pkg::PHASE_IDLE: begin
              if (contactor_bits == 3'b000) phase_reg_next = bpc_pkg::PHASE_PRE;
            end
            bpc_pkg::PHASE_PRE: begin
              wait_timer_next = 16'd0;
              if (cfg.precharge_ms == 16'd0) begin
                contactor_bits_next = (contactor_bits | bpc_pkg::CON_NEG | bpc_pkg::CON_POS)
                                      & ~bpc_pkg::CON_PRE;
                phase_reg_next      = bpc_pkg::PHASE_RUN;
              end else begin
                contactor_bits_next = contactor_bits | bpc_pkg::CON_PRE | bpc_pkg::CON_NEG;
                phase_reg_next      = bpc_pkg::PHASE_WAIT;
              end
            end
            bpc_pkg::PHASE_WAIT: begin
              wait_timer_next = wait_inc;
              if (wait_inc >= cfg.precharge_ms) begin
                contactor_bits_next = (contactor_bits | bpc_pkg::CON_POS) & ~bpc_pkg::CON_PRE;
                phase_reg_next      = bpc_pkg::PHASE_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      bpc_pkg::KIND_FRAME: begin
        if (frame_fault && !fault_flag) begin
          fault_flag_next = 1'b1;
          cause_reg_next  = frame_cause;
        end
      end
      bpc_pkg::KIND_TRIP: begin
        contactor_bits_next = contactor_bits & ~(bpc_pkg::CON_POS | bpc_pkg::CON_NEG);
        if (!fault_flag) begin
          fault_flag_next = 1'b1;
          cause_reg_next  = bpc_pkg::CAUSE_ESTOP;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_flag     <= 1'b0;
      cause_reg      <= bpc_pkg::CAUSE_NONE;
      phase_reg      <= bpc_pkg::PHASE_IDLE;
      contactor_bits <= 3'b000;
      lamp_reg       <= 1'b0;
      wait_timer     <= 16'd0;
      blink_timer    <= 16'd0;
      hold_timer     <= 16'd0;
      holding_flag   <= 1'b0;
    end else if (step) begin
      fault_flag     <= fault_flag_next;
      cause_reg      <= cause_reg_next;
      phase_reg      <= phase_reg_next;
      contactor_bits <= contactor_bits_next;
      lamp_reg       <= lamp_reg_next;
      wait_timer     <= wait_timer_next;
      blink_timer    <= blink_timer_next;
      hold_timer     <= hold_timer_next;
      holding_flag   <= holding_flag_next;
    end
  end

  // the state registers double as the result register
  always_comb begin
    res.precharge_closed = contactor_bits[0];
    res.positive_closed  = contactor_bits[1];
    res.negative_closed  = contactor_bits[2];
    res.fault_lamp       = lamp_reg;
    res.fault_active     = fault_flag;
    res.phase            = phase_reg;
    res.fault_cause      = cause_reg;
  end

endmodule

// ----- rtl/core/bpc_checker.sv -----
module bpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_fault_has_cause: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[9:7] != bpc_pkg::CAUSE_NONE)
    else $error("fault latched without a cause");

  a_clear_means_quiet: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[4]
      |-> m_axis_tdata[9:7] == bpc_pkg::CAUSE_NONE && !m_axis_tdata[3])
    else $error("cause or lamp set without a fault");

  a_run_contactors: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[4] && m_axis_tdata[6:5] == bpc_pkg::PHASE_RUN
      |-> m_axis_tdata[1] && !m_axis_tdata[0] && m_axis_tdata[2])
    else $error("running without positive and negative closed");

endmodule

bind battery_protection_controller bpc_checker u_bpc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- dv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // tuser code outside the defined kinds; the block must leave its state alone
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [bpc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]                     s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [bpc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [15:0]                    cfg_data = '0;

  // set during the stretch where neither side idles
  bit calm = 1'b0;

  // protection state as the block should hold it
  bpc_pkg::cfg_t   limits;
  bit              faulted;
  bpc_pkg::cause_t cause;
  bpc_pkg::phase_t ph;
  logic [2:0]      contactors;
  logic            lamp;
  logic [15:0]     wait_cnt;
  logic [15:0]     blink_cnt;
  logic [15:0]     hold_cnt;
  bit              holding;

  bpc_pkg::result_t pending_status[$];
  bpc_pkg::result_t got, want;

  int mismatches;
  int n_checked, n_ticks, n_frames, n_trips, n_spare;
  int n_faults, n_clears, n_runs, n_settings;

  always #10 clk = ~clk;

  battery_protection_controller dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic void clear_protection();
    limits.charge_lim    = bpc_pkg::RST_CHARGE_LIM;
    limits.discharge_lim = bpc_pkg::RST_DISCHARGE_LIM;
    limits.cell_over     = bpc_pkg::RST_CELL_OVER;
    limits.cell_under    = bpc_pkg::RST_CELL_UNDER;
    limits.precharge_ms  = bpc_pkg::RST_PRECHARGE_MS;
    limits.blink_ms      = bpc_pkg::RST_BLINK_MS;
    limits.hold_ms       = bpc_pkg::RST_HOLD_MS;
    faulted    = 1'b0;
    cause      = bpc_pkg::CAUSE_NONE;
    ph         = bpc_pkg::PHASE_IDLE;
    contactors = '0;
    lamp       = 1'b0;
    wait_cnt   = '0;
    blink_cnt  = '0;
    hold_cnt   = '0;
    holding    = 1'b0;
  endfunction

  function automatic void raise_fault(input bpc_pkg::cause_t c);
    if (!faulted) begin
      faulted = 1'b1;
      cause   = c;
      n_faults++;
    end
  endfunction

  function automatic void close_positive();
    contactors = (contactors | bpc_pkg::CON_POS) & ~bpc_pkg::CON_PRE;
    ph         = bpc_pkg::PHASE_RUN;
    n_runs++;
  endfunction

  // applies one beat to the tracked state and queues the status it must produce
  function automatic void advance_protection(input logic [1:0] kind, input logic level,
                                             input logic [10:0] id, input logic [63:0] data);
    bpc_pkg::result_t r;
    logic [15:0]      hi_word;
    logic [15:0]      lo_word;
    hi_word = data[63:48];
    lo_word = data[39:24];
    case (kind)
      bpc_pkg::KIND_TICK: begin
        n_ticks++;
        blink_cnt = bump(blink_cnt);
        if (faulted) begin
          if (blink_cnt >= limits.blink_ms) begin
            lamp      = ~lamp;
            blink_cnt = '0;
          end
          if (!level) begin
            if (!holding) begin
              holding  = 1'b1;
              hold_cnt = '0;
            end else begin
              hold_cnt = bump(hold_cnt);
              if (hold_cnt > limits.hold_ms) begin
                faulted    = 1'b0;
                cause      = bpc_pkg::CAUSE_NONE;
                holding    = 1'b0;
                hold_cnt   = '0;
                lamp       = 1'b0;
                contactors = '0;
                ph         = bpc_pkg::PHASE_IDLE;
                n_clears++;
              end
            end
          end else begin
            holding = 1'b0;
          end
        end else begin
          lamp = 1'b0;
          case (ph)
            bpc_pkg::PHASE_IDLE: begin
              if (contactors == '0) ph = bpc_pkg::PHASE_PRE;
            end
            bpc_pkg::PHASE_PRE: begin
              // precharge and negative close, and waiting starts in the same tick
              contactors = contactors | bpc_pkg::CON_PRE | bpc_pkg::CON_NEG;
              wait_cnt   = '0;
              ph         = bpc_pkg::PHASE_WAIT;
              if (limits.precharge_ms == '0) close_positive();
            end
            bpc_pkg::PHASE_WAIT: begin
              wait_cnt = bump(wait_cnt);
              if (wait_cnt >= limits.precharge_ms) close_positive();
            end
            default: ;
          endcase
        end
      end
      bpc_pkg::KIND_FRAME: begin
        n_frames++;
        if (id == bpc_pkg::ID_BATT_CURRENT) begin
          if ($signed(hi_word) < $signed(limits.charge_lim))
            raise_fault(bpc_pkg::CAUSE_CHARGE);
          else if ($signed(hi_word) > $signed(limits.discharge_lim))
            raise_fault(bpc_pkg::CAUSE_DISCHARGE);
        end else if (id == bpc_pkg::ID_CELL_VOLTAGE) begin
          if (hi_word > limits.cell_over) raise_fault(bpc_pkg::CAUSE_CELL_OVER);
          else if (lo_word <= limits.cell_under) raise_fault(bpc_pkg::CAUSE_CELL_UNDR);
        end
      end
      bpc_pkg::KIND_TRIP: begin
        n_trips++;
        contactors = contactors & ~(bpc_pkg::CON_POS | bpc_pkg::CON_NEG);
        raise_fault(bpc_pkg::CAUSE_ESTOP);
      end
      default: n_spare++;
    endcase
    r.precharge_closed = contactors[0];
    r.positive_closed  = contactors[1];
    r.negative_closed  = contactors[2];
    r.fault_lamp       = lamp;
    r.fault_active     = faulted;
    r.phase            = ph;
    r.fault_cause      = cause;
    pending_status.push_back(r);
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic level,
                           input logic [10:0] id, input logic [63:0] data);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0, data, id, level};
    do @(posedge clk); while (!s_axis_tready);
    advance_protection(kind, level, id, data);
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bpc_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bpc_pkg::REG_CHARGE_LIM:    limits.charge_lim    = val;
      bpc_pkg::REG_DISCHARGE_LIM: limits.discharge_lim = val;
      bpc_pkg::REG_CELL_OVER:     limits.cell_over     = val;
      bpc_pkg::REG_CELL_UNDER:    limits.cell_under    = val;
      bpc_pkg::REG_PRECHARGE_MS:  limits.precharge_ms  = val;
      bpc_pkg::REG_BLINK_MS:      limits.blink_ms      = val;
      bpc_pkg::REG_HOLD_MS:       limits.hold_ms       = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_limits(input int chg, input int dis, input int over, input int under,
                              input int pre, input int blink, input int hold);
    write_reg(bpc_pkg::REG_CHARGE_LIM, 16'(chg));
    write_reg(bpc_pkg::REG_DISCHARGE_LIM, 16'(dis));
    write_reg(bpc_pkg::REG_CELL_OVER, 16'(over));
    write_reg(bpc_pkg::REG_CELL_UNDER, 16'(under));
    write_reg(bpc_pkg::REG_PRECHARGE_MS, 16'(pre));
    write_reg(bpc_pkg::REG_BLINK_MS, 16'(blink));
    write_reg(bpc_pkg::REG_HOLD_MS, 16'(hold));
    n_settings++;
  endtask

  function automatic logic [63:0] cell_payload(input logic [15:0] hi, input logic [15:0] lo,
                                               input logic [63:0] filler);
    return {hi, filler[47:40], lo, filler[23:0]};
  endfunction

  // near the limit, anywhere, or a value that passes
  function automatic logic [15:0] probe_value(input logic [15:0] lim, input logic [15:0] pass);
    case ($urandom_range(3))
      0:       return lim + 16'($urandom_range(6)) - 16'd3;
      1:       return 16'($urandom);
      default: return pass;
    endcase
  endfunction

  task automatic send_random_item();
    int unsigned roll;
    int unsigned pick;
    logic [63:0] filler;
    logic [15:0] bound;
    logic [10:0] id;
    roll   = $urandom_range(99);
    pick   = $urandom_range(9);
    filler = {$urandom, $urandom};
    id     = 11'($urandom);
    // a faulted block mostly sees e-stop held low, so faults clear and sequences restart
    if (faulted) begin
      if (roll < 70) roll = 0;
      else if (roll < 78) roll = 1;
      else if (roll < 90) roll = 2;
      else if (roll < 95) roll = 3;
      else roll = 4;
    end else begin
      if (roll < 77) roll = 1;
      else if (roll < 80) roll = 0;
      else if (roll < 95) roll = 2;
      else if (roll < 98) roll = 3;
      else roll = 4;
    end
    case (roll)
      0: send_item(bpc_pkg::KIND_TICK, 1'b0, id, filler);
      1: send_item(bpc_pkg::KIND_TICK, 1'b1, id, filler);
      2: begin
        if (pick < 4) begin
          bound = $urandom_range(1) ? limits.charge_lim : limits.discharge_lim;
          send_item(bpc_pkg::KIND_FRAME, 1'($urandom), bpc_pkg::ID_BATT_CURRENT,
                    {probe_value(bound, bound), filler[47:0]});
        end else if (pick < 8) begin
          send_item(bpc_pkg::KIND_FRAME, 1'($urandom), bpc_pkg::ID_CELL_VOLTAGE,
                    cell_payload(probe_value(limits.cell_over, limits.cell_over),
                                 probe_value(limits.cell_under, limits.cell_under + 16'd1),
                                 filler));
        end else begin
          send_item(bpc_pkg::KIND_FRAME, 1'($urandom), id, filler);
        end
      end
      3: send_item(bpc_pkg::KIND_TRIP, 1'($urandom), id, filler);
      default: send_item(KIND_SPARE, 1'($urandom), id, filler);
    endcase
  endtask

  task automatic run_phase(input int n_items);
    for (int i = 0; i < n_items; i++) send_random_item();
    drain();
  endtask

  // limits straight out of reset: boundaries that must pass, then latching and trip
  task automatic test_default_limits();
    send_item(bpc_pkg::KIND_TICK, 1'b1, '0, '0);
    send_item(bpc_pkg::KIND_TICK, 1'b1, '0, '0);
    send_item(bpc_pkg::KIND_FRAME, 1'b0, bpc_pkg::ID_BATT_CURRENT, {16'hFFEC, 48'h0});
    send_item(bpc_pkg::KIND_FRAME, 1'b0, bpc_pkg::ID_BATT_CURRENT, {16'd100, 48'h0});
    send_item(bpc_pkg::KIND_FRAME, 1'b0, bpc_pkg::ID_CELL_VOLTAGE,
              cell_payload(16'd4, 16'd3, '0));
    send_item(bpc_pkg::KIND_FRAME, 1'b1, bpc_pkg::ID_BATT_CURRENT + 11'd1, '1);
    send_item(KIND_SPARE, 1'b1, '1, '1);
    send_item(bpc_pkg::KIND_FRAME, 1'b0, bpc_pkg::ID_BATT_CURRENT, {16'd101, 48'h0});
    // already latched: cause stays discharge
    send_item(bpc_pkg::KIND_FRAME, 1'b0, bpc_pkg::ID_BATT_CURRENT, {16'hFFEB, 48'h0});
    send_item(bpc_pkg::KIND_TRIP, 1'b0, '0, '0);
    drain();
  endtask

  task automatic test_special_cases();
    apply_limits(-5, 5, 4000, 3000, 0, 1, 0);
    send_item(bpc_pkg::KIND_TICK, 1'b0, '0, '0);
    send_item(bpc_pkg::KIND_TICK, 1'b0, '0, '0);
    // zero precharge time: positive closes in the precharge tick
    send_item(bpc_pkg::KIND_TICK, 1'b1, '0, '0);
    send_item(bpc_pkg::KIND_TICK, 1'b1, '0, '0);
    send_item(bpc_pkg::KIND_FRAME, 1'b0, bpc_pkg::ID_BATT_CURRENT, {16'hFFFB, 48'h0});
    send_item(bpc_pkg::KIND_FRAME, 1'b0, bpc_pkg::ID_CELL_VOLTAGE,
              cell_payload(16'd4000, 16'd3001, '0));
    send_item(bpc_pkg::KIND_FRAME, 1'b1, bpc_pkg::ID_BATT_CURRENT,
              {16'h8000, 48'hFFFF_FFFF_FFFF});
    send_item(bpc_pkg::KIND_TICK, 1'b0, '1, '1);
    send_item(bpc_pkg::KIND_TICK, 1'b0, '1, '1);
    send_item(bpc_pkg::KIND_TICK, 1'b1, '0, '0);
    // low cell exactly at the limit faults
    send_item(bpc_pkg::KIND_FRAME, 1'b0, bpc_pkg::ID_CELL_VOLTAGE,
              cell_payload(16'd0, 16'd3000, '1));
    send_item(bpc_pkg::KIND_TRIP, 1'b1, '1, '1);
    send_item(bpc_pkg::KIND_FRAME, 1'b0, bpc_pkg::ID_BATT_CURRENT, {16'h7FFF, 48'h0});
    send_item(bpc_pkg::KIND_FRAME, 1'b1, 11'h7FF, '1);
    send_item(bpc_pkg::KIND_FRAME, 1'b0, 11'h000, '0);
    drain();
  endtask

  task automatic test_extreme_limits();
    apply_limits(-32768, 32767, 65535, 0, 0, 1, 0);
    run_phase(200);
    // everything faults, nothing clears or finishes
    apply_limits(32767, -32768, 0, 65535, 65535, 65535, 65535);
    run_phase(100);
    // zero blink period toggles the lamp on every faulted tick
    apply_limits(0, 0, 2048, 2048, 1, 0, 3);
    run_phase(200);
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 5; p++) begin
      apply_limits(-int'($urandom_range(200)), $urandom_range(200),
                   $urandom_range(4000, 1000), $urandom_range(3000, 100),
                   $urandom_range(12), $urandom_range(6), $urandom_range(10));
      calm = (p == 2);
      run_phase(200);
      calm = 1'b0;
    end
  endtask

  always @(negedge clk) m_axis_tready <= calm || ($urandom_range(99) >= 8);

  function automatic void check_field(input string name, input logic [5:0] want_v,
                                      input logic [5:0] got_v);
    if (got_v !== want_v) begin
      if (mismatches < 50)
        $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = bpc_pkg::result_t'(m_axis_tdata[9:0]);
      if (pending_status.size() == 0) begin
        if (mismatches < 50)
          $display("%0t: result beat with none expected, tdata %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        n_checked++;
        check_field("precharge_closed", want.precharge_closed, got.precharge_closed);
        check_field("positive_closed", want.positive_closed, got.positive_closed);
        check_field("negative_closed", want.negative_closed, got.negative_closed);
        check_field("fault_lamp", want.fault_lamp, got.fault_lamp);
        check_field("fault_active", want.fault_active, got.fault_active);
        check_field("phase", want.phase, got.phase);
        check_field("fault_cause", want.fault_cause, got.fault_cause);
        check_field("tdata pad", '0, m_axis_tdata[15:10]);
      end
    end
  end

  initial begin
    clear_protection();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_default_limits();
    test_special_cases();
    test_extreme_limits();
    test_random_traffic();
    $display("Sent %0d ticks, %0d CAN frames, %0d trips, %0d unused-kind beats over %0d settings",
             n_ticks, n_frames, n_trips, n_spare, n_settings + 1);
    $display("Checked %0d status beats; %0d faults latched, %0d cleared, %0d runs reached",
             n_checked, n_faults, n_clears, n_runs);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d status beats outstanding", pending_status.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
